// ----- rtl/core/htsm_pkg.sv -----
// Package for the header table size manager: field widths, table limits,
// action and sequencer codes, and the beat structures. No dependencies.
package htsm_pkg;

   localparam int TABLE_BYTES_LIMIT = 4096;
   localparam int MAX_ENTRIES       = 128;
   localparam int ENTRY_OVERHEAD    = 32;

   localparam int LEN_W  = 13;
   localparam int SLOT_W = 7;
   localparam int CNT_W  = 8;
   localparam int COST_W = 15;
   localparam int SUM_W  = 16;
   localparam int REQ_W  = 16;
   localparam int POS_W  = 7;

   localparam logic [LEN_W-1:0] LIMIT_BYTES = LEN_W'(TABLE_BYTES_LIMIT);
   localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ACT_PUSH,
      ACT_RESIZE,
      ACT_LOOKUP,
      ACT_NOP
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_EVICT,
      S_LOOK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] value_len;
      logic [LEN_W-1:0] name_len;
   } entry_type;

   typedef struct packed {
      action_type        action;
      logic [LEN_W-1:0]  name_len;
      logic [LEN_W-1:0]  value_len;
      logic [REQ_W-1:0]  new_max;
      logic [POS_W-1:0]  pos;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  name_len;
      logic [LEN_W-1:0]  value_len;
      logic              stored;
      logic [CNT_W-1:0]  evicted;
      logic [LEN_W-1:0]  size;
      logic [CNT_W-1:0]  count;
      logic              clamped;
   } rsp_type;

   function automatic logic [COST_W-1:0] entry_cost(input entry_type e);
      return COST_W'(e.name_len) + COST_W'(e.value_len) + COST_W'(ENTRY_OVERHEAD);
   endfunction

endpackage

// ----- rtl/core/header_table_size_manager_top.sv -----
// Top level of the header table size manager: request and response beats,
// output register and control register port. Depends on htsm_pkg, htsm_core.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    action, lengths, new max, position
//   rsp      out        rsp_valid/ready    slot, lengths, stored, counts, clamp
//   csr      in         csr_we             max size limit, 13 bits
//
// A beat goes from accept to check to done (lookup also reads), plus an evict
// per entry evicted to make room; an oversized push clears the table at once.
// A csr write runs the same eviction loop and holds req_ready low until done.
// Reset is synchronous: empty table, limit 4096. A stalled response holds in
// the output register; a new beat is taken meanwhile, and its response waits
// for the register to free.
module header_table_size_manager_top
   import htsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [LEN_W-1:0]  req_name_length,
   input  logic [LEN_W-1:0]  req_value_length,
   input  logic [REQ_W-1:0]  req_new_max_size,
   input  logic [POS_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [LEN_W-1:0]  rsp_entry_name_length,
   output logic [LEN_W-1:0]  rsp_entry_value_length,
   output logic              rsp_stored,
   output logic [CNT_W-1:0]  rsp_evicted_count,
   output logic [LEN_W-1:0]  rsp_current_size,
   output logic [CNT_W-1:0]  rsp_entry_count,
   output logic              rsp_size_clamped,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata
);

   logic    core_idle;
   logic    core_done;
   logic    out_free;
   logic    start;
   req_type req;
   rsp_type core_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   assign req_ready = core_idle && !csr_we;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req = '{action:    action_type'(req_action),
                  name_len:  req_name_length,
                  value_len: req_value_length,
                  new_max:   req_new_max_size,
                  pos:       req_position};

   htsm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .out_free  (out_free),
      .idle      (core_idle),
      .done      (core_done),
      .rsp       (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_slot               = rsp_ff.slot;
   assign rsp_entry_name_length  = rsp_ff.name_len;
   assign rsp_entry_value_length = rsp_ff.value_len;
   assign rsp_stored             = rsp_ff.stored;
   assign rsp_evicted_count      = rsp_ff.evicted;
   assign rsp_current_size       = rsp_ff.size;
   assign rsp_entry_count        = rsp_ff.count;
   assign rsp_size_clamped       = rsp_ff.clamped;

endmodule

// ----- rtl/core/htsm_ring.sv -----
// Ring of entry lengths, one write port and one registered read port.
// Depends on htsm_pkg.
module htsm_ring
   import htsm_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [SLOT_W-1:0] rd_addr,
   output entry_type         rd_data_ff
);

   entry_type ring_mem_ff [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/htsm_core.sv -----
// Sequencer and shared size accounting datapath of the header table.
// Depends on htsm_pkg and htsm_ring.
module htsm_core
   import htsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output rsp_type          rsp
);

   state_type         state_ff, state_in;
   req_type           op_ff, op_in;
   logic              is_cfg_ff, is_cfg_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic [LEN_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  rname_ff, rname_in;
   logic [LEN_W-1:0]  rvalue_ff, rvalue_in;
   logic              stored_ff, stored_in;
   logic [CNT_W-1:0]  evicted_ff, evicted_in;
   logic              clamped_ff, clamped_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_data;
   logic [SLOT_W-1:0] oldest_slot;
   logic [SLOT_W-1:0] lookup_slot;
   logic [SUM_W-1:0]  fit_sum;
   logic [COST_W-1:0] evict_cost;

   htsm_ring u_ring (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign oldest_slot = newest_ff - held_ff[SLOT_W-1:0] + SLOT_W'(1);
   assign lookup_slot = newest_ff - SLOT_W'(op_ff.pos);
   assign fit_sum     = SUM_W'(used_ff) + SUM_W'(cost_ff);
   assign evict_cost  = entry_cost(rd_data);
   assign wr_addr     = newest_ff + SLOT_W'(1);
   assign wr_data     = '{value_len: op_ff.value_len, name_len: op_ff.name_len};
   assign idle        = (state_ff == S_IDLE);

   assign rsp = '{slot:      slot_ff,
                  name_len:  rname_ff,
                  value_len: rvalue_ff,
                  stored:    stored_ff,
                  evicted:   evicted_ff,
                  size:      used_ff,
                  count:     held_ff,
                  clamped:   clamped_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         limit_ff  <= LIMIT_BYTES;
         used_ff   <= '0;
         held_ff   <= '0;
         newest_ff <= '0;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         used_ff   <= used_in;
         held_ff   <= held_in;
         newest_ff <= newest_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      is_cfg_ff  <= is_cfg_in;
      cost_ff    <= cost_in;
      slot_ff    <= slot_in;
      rname_ff   <= rname_in;
      rvalue_ff  <= rvalue_in;
      stored_ff  <= stored_in;
      evicted_ff <= evicted_in;
      clamped_ff <= clamped_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      is_cfg_in  = is_cfg_ff;
      cost_in    = cost_ff;
      limit_in   = limit_ff;
      used_in    = used_ff;
      held_in    = held_ff;
      newest_in  = newest_ff;
      slot_in    = slot_ff;
      rname_in   = rname_ff;
      rvalue_in  = rvalue_ff;
      stored_in  = stored_ff;
      evicted_in = evicted_ff;
      clamped_in = clamped_ff;
      wr_en      = 1'b0;
      rd_addr    = oldest_slot;
      done       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            slot_in    = '0;
            rname_in   = '0;
            rvalue_in  = '0;
            stored_in  = 1'b0;
            evicted_in = '0;
            clamped_in = 1'b0;
            if (csr_we) begin
               op_in.action = ACT_RESIZE;
               is_cfg_in    = 1'b1;
               cost_in      = '0;
               limit_in     = (csr_wdata > LIMIT_BYTES) ? LIMIT_BYTES : csr_wdata;
               state_in     = S_CHECK;
            end else if (start) begin
               op_in     = req;
               is_cfg_in = 1'b0;
               cost_in   = '0;
               if (req.action == ACT_PUSH) begin
                  cost_in = entry_cost('{value_len: req.value_len,
                                         name_len:  req.name_len});
               end
               if (req.action == ACT_RESIZE) begin
                  if (req.new_max > REQ_W'(TABLE_BYTES_LIMIT)) begin
                     limit_in   = LIMIT_BYTES;
                     clamped_in = 1'b1;
                  end else begin
                     limit_in = req.new_max[LEN_W-1:0];
                  end
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (op_ff.action)
               ACT_PUSH: begin
                  if (cost_ff > COST_W'(limit_ff)) begin
                     evicted_in = evicted_ff + held_ff;
                     held_in    = '0;
                     used_in    = '0;
                     state_in   = S_DONE;
                  end else if (held_ff != '0 &&
                               (fit_sum > SUM_W'(limit_ff) || held_ff == FULL_COUNT)) begin
                     state_in = S_EVICT;
                  end else begin
                     wr_en     = 1'b1;
                     newest_in = wr_addr;
                     held_in   = held_ff + CNT_W'(1);
                     used_in   = used_ff + cost_ff[LEN_W-1:0];
                     slot_in   = wr_addr;
                     stored_in = 1'b1;
                     state_in  = S_DONE;
                  end
               end
               ACT_RESIZE: begin
                  if (held_ff != '0 && fit_sum > SUM_W'(limit_ff)) begin
                     state_in = S_EVICT;
                  end else begin
                     state_in = is_cfg_ff ? S_IDLE : S_DONE;
                  end
               end
               ACT_LOOKUP: begin
                  rd_addr = lookup_slot;
                  if (CNT_W'(op_ff.pos) < held_ff) begin
                     slot_in   = lookup_slot;
                     stored_in = 1'b1;
                     state_in  = S_LOOK;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_EVICT: begin
            held_in    = held_ff - CNT_W'(1);
            evicted_in = evicted_ff + CNT_W'(1);
            if (held_ff == CNT_W'(1) || evict_cost > COST_W'(used_ff)) begin
               used_in = '0;
            end else begin
               used_in = used_ff - evict_cost[LEN_W-1:0];
            end
            state_in = S_CHECK;
         end
         S_LOOK: begin
            rname_in  = rd_data.name_len;
            rvalue_in = rd_data.value_len;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      held_ff == '0 |-> used_ff == '0)
      else $error("table empty but byte count nonzero");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL_COUNT)
      else $error("entry count above ring depth");

   a_idle_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> used_ff <= limit_ff)
      else $error("table size above limit while idle");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVICT |-> held_ff != '0)
      else $error("eviction from an empty table");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Testbench for header_table_size_manager_top: directed, wrap, limit register,
// backpressure and random tests checked beat by beat against an in-bench table
// model. Depends on htsm_pkg and the RTL of the block only.
module tb_top;
   import htsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD  = 400;
   localparam int DRAIN_WAIT = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action = '0;
   logic [LEN_W-1:0]  req_name_length = '0;
   logic [LEN_W-1:0]  req_value_length = '0;
   logic [REQ_W-1:0]  req_new_max_size = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SLOT_W-1:0] rsp_slot;
   logic [LEN_W-1:0]  rsp_entry_name_length;
   logic [LEN_W-1:0]  rsp_entry_value_length;
   logic              rsp_stored;
   logic [CNT_W-1:0]  rsp_evicted_count;
   logic [LEN_W-1:0]  rsp_current_size;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic              rsp_size_clamped;
   logic              csr_we = 1'b0;
   logic [LEN_W-1:0]  csr_wdata = '0;

   // table model state
   logic [LEN_W-1:0] tbl_name  [MAX_ENTRIES];
   logic [LEN_W-1:0] tbl_value [MAX_ENTRIES];
   int head_slot    = 0;
   int live_entries = 0;
   int bytes_used   = 0;
   int bytes_limit  = TABLE_BYTES_LIMIT;

   rsp_type pending_rsp[$];

   int errors = 0;
   int beats_sent = 0;
   int pushes_stored = 0;
   int oversized_drops = 0;
   int lookup_hits = 0;
   int entries_evicted = 0;
   int clamped_resizes = 0;
   int limit_writes = 0;

   int burst_left = 0;
   bit no_gaps = 1'b0;
   int long_holds_asked = 0;
   int long_holds_done = 0;

   header_table_size_manager_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_name_length        (req_name_length),
      .req_value_length       (req_value_length),
      .req_new_max_size       (req_new_max_size),
      .req_position           (req_position),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_slot               (rsp_slot),
      .rsp_entry_name_length  (rsp_entry_name_length),
      .rsp_entry_value_length (rsp_entry_value_length),
      .rsp_stored             (rsp_stored),
      .rsp_evicted_count      (rsp_evicted_count),
      .rsp_current_size       (rsp_current_size),
      .rsp_entry_count        (rsp_entry_count),
      .rsp_size_clamped       (rsp_size_clamped),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void evict_oldest_entry();
      int oldest;
      int cost;
      oldest = (head_slot + MAX_ENTRIES - (live_entries - 1)) % MAX_ENTRIES;
      cost = int'(tbl_name[oldest]) + int'(tbl_value[oldest]) + ENTRY_OVERHEAD;
      bytes_used = (cost > bytes_used) ? 0 : bytes_used - cost;
      live_entries--;
   endfunction

   function automatic int shrink_to_fit(input int extra);
      int n;
      n = 0;
      while (live_entries > 0 && bytes_used + extra > bytes_limit) begin
         evict_oldest_entry();
         n++;
      end
      if (live_entries == 0) bytes_used = 0;
      return n;
   endfunction

   function automatic rsp_type table_outcome(input action_type act, input int nlen,
                                             input int vlen, input int req, input int pos);
      rsp_type r;
      int cost;
      int ev;
      r = '0;
      ev = 0;
      case (act)
         ACT_PUSH: begin
            cost = nlen + vlen + ENTRY_OVERHEAD;
            if (cost > bytes_limit) begin
               ev = live_entries;
               live_entries = 0;
               bytes_used = 0;
               oversized_drops++;
            end else begin
               ev = shrink_to_fit(cost);
               if (live_entries >= MAX_ENTRIES) begin
                  evict_oldest_entry();
                  ev++;
               end
               head_slot = (head_slot + 1) % MAX_ENTRIES;
               tbl_name[head_slot]  = LEN_W'(nlen);
               tbl_value[head_slot] = LEN_W'(vlen);
               live_entries++;
               bytes_used += cost;
               r.slot   = SLOT_W'(head_slot);
               r.stored = 1'b1;
               pushes_stored++;
            end
         end
         ACT_RESIZE: begin
            if (req > TABLE_BYTES_LIMIT) begin
               req = TABLE_BYTES_LIMIT;
               r.clamped = 1'b1;
               clamped_resizes++;
            end
            bytes_limit = req;
            ev = shrink_to_fit(0);
         end
         ACT_LOOKUP: begin
            if (pos < live_entries) begin
               r.slot      = SLOT_W'((head_slot + MAX_ENTRIES - pos) % MAX_ENTRIES);
               r.name_len  = tbl_name[r.slot];
               r.value_len = tbl_value[r.slot];
               r.stored    = 1'b1;
               lookup_hits++;
            end
         end
         default: ;
      endcase
      entries_evicted += ev;
      r.evicted = CNT_W'(ev);
      r.size    = LEN_W'(bytes_used);
      r.count   = CNT_W'(live_entries);
      return r;
   endfunction

   task automatic check_field(input string fname, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t ns: result beat with none pending, expected nothing, actual size %0d",
                     $time, rsp_current_size);
         end else begin
            want = pending_rsp.pop_front();
            check_field("slot", int'(want.slot), int'(rsp_slot));
            check_field("entry_name_length", int'(want.name_len),
                        int'(rsp_entry_name_length));
            check_field("entry_value_length", int'(want.value_len),
                        int'(rsp_entry_value_length));
            check_field("stored", int'(want.stored), int'(rsp_stored));
            check_field("evicted_count", int'(want.evicted), int'(rsp_evicted_count));
            check_field("current_size", int'(want.size), int'(rsp_current_size));
            check_field("entry_count", int'(want.count), int'(rsp_entry_count));
            check_field("size_clamped", int'(want.clamped), int'(rsp_size_clamped));
         end
      end
   end

   initial begin : rsp_side
      int hold_left;
      int mode;
      int mode_left;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (hold_left == 0 && long_holds_done < long_holds_asked) begin
            hold_left = LONG_HOLD;
            long_holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= mode_left[2];
            endcase
         end
      end
   end

   task automatic send_beat(input action_type act, input int nlen, input int vlen,
                            input int req, input int pos);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_name_length  <= LEN_W'(nlen);
      req_value_length <= LEN_W'(vlen);
      req_new_max_size <= REQ_W'(req);
      req_position     <= POS_W'(pos);
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_outcome(act, nlen, vlen, req, pos));
      beats_sent++;
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(0, 24);
         end
      end
   endtask

   task automatic push_entry(input int nlen, input int vlen);
      send_beat(ACT_PUSH, nlen, vlen, $urandom_range(0, 65535), $urandom_range(0, 127));
   endtask

   task automatic request_resize(input int req);
      send_beat(ACT_RESIZE, $urandom_range(0, 4096), $urandom_range(0, 4096), req,
                $urandom_range(0, 127));
   endtask

   task automatic lookup_entry(input int pos);
      send_beat(ACT_LOOKUP, $urandom_range(0, 4096), $urandom_range(0, 4096),
                $urandom_range(0, 65535), pos);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // table is idle here; follow each write with a beat so writes never overlap eviction
   task automatic write_limit(input int value);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= LEN_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      bytes_limit = (value > TABLE_BYTES_LIMIT) ? TABLE_BYTES_LIMIT : value;
      void'(shrink_to_fit(0));
      limit_writes++;
      send_beat(ACT_NOP, 0, 0, 0, 0);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 60);
      if (r < 95) return $urandom_range(0, 1500);
      if (r < 98) return $urandom_range(0, 4096);
      return 4096;
   endfunction

   task automatic send_random_beat();
      int r;
      int s;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         push_entry(pick_length(), pick_length());
      end else if (r < 82) begin
         if (live_entries > 0 && $urandom_range(0, 99) < 80)
            lookup_entry($urandom_range(0, live_entries - 1));
         else
            lookup_entry($urandom_range(0, 127));
      end else if (r < 97) begin
         s = $urandom_range(0, 99);
         if (s < 55)      request_resize($urandom_range(200, 4096));
         else if (s < 70) request_resize($urandom_range(0, 200));
         else if (s < 85) request_resize(4096);
         else             request_resize($urandom_range(4097, 65535));
      end else begin
         send_beat(ACT_NOP, $urandom_range(0, 4096), $urandom_range(0, 4096),
                   $urandom_range(0, 65535), $urandom_range(0, 127));
      end
   endtask

   task automatic test_directed_edges();
      lookup_entry(0);
      send_beat(ACT_NOP, 4096, 4096, 65535, 127);
      push_entry(0, 0);
      push_entry(4096, 0);
      push_entry(4064, 0);
      push_entry(0, 4064);
      push_entry(5, 7);
      lookup_entry(0);
      lookup_entry(1);
      lookup_entry(127);
      push_entry(100, 200);
      push_entry(4096, 4096);
      push_entry(1, 2);
      request_resize(65535);
      request_resize(4097);
      request_resize(4096);
      request_resize(0);
      push_entry(0, 0);
      request_resize(32);
      push_entry(0, 0);
      push_entry(0, 0);
      request_resize(4096);
      push_entry(2730, 1333);
      lookup_entry(0);
   endtask

   task automatic test_table_wrap();
      request_resize(4096);
      repeat (140) push_entry($urandom_range(0, 2), $urandom_range(0, 2));
      for (int p = 0; p < MAX_ENTRIES; p++) lookup_entry(p);
   endtask

   task automatic test_limit_register();
      write_limit(0);
      push_entry(0, 0);
      write_limit(4096);
      repeat (40) push_entry($urandom_range(0, 60), $urandom_range(0, 60));
      write_limit(1000);
      lookup_entry(0);
      write_limit(4095);
      repeat (10) push_entry($urandom_range(0, 300), $urandom_range(0, 300));
      write_limit(4096);
   endtask

   task automatic test_output_backpressure();
      no_gaps = 1'b1;
      long_holds_asked++;
      repeat (40) send_random_beat();
      no_gaps = 1'b0;
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int phase_limit [5];
      phase_limit[0] = $urandom_range(0, 4096);
      phase_limit[1] = 4096;
      phase_limit[2] = 512;
      phase_limit[3] = $urandom_range(1000, 4096);
      phase_limit[4] = 4096;
      for (int ph = 0; ph < 5; ph++) begin
         write_limit(phase_limit[ph]);
         no_gaps = (ph == 2);
         repeat (300) send_random_beat();
      end
      no_gaps = 1'b0;
   endtask

   task automatic finish_run();
      wait_drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d request beats: %0d stored pushes, %0d oversized drops,",
               beats_sent, pushes_stored, oversized_drops);
      $display("%0d lookup hits, %0d evicted entries, %0d clamped resizes, %0d limit writes.",
               lookup_hits, entries_evicted, clamped_resizes, limit_writes);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_table_wrap();
      test_limit_register();
      test_output_backpressure();
      test_random_traffic();
      finish_run();
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
